[rtl/lac_pkg.sv]
// Shared types, codes and helpers for the layer alpha compositor.
// Used by lac_ctrl, lac_dp and layer_alpha_compositor; depends on nothing.
`timescale 1ns / 1ps

package lac_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [31:0] WORD_TRANSPARENT = 32'h0000_0000;
  localparam logic [31:0] WORD_BLACK       = 32'hFF00_0000;

  typedef enum logic [1:0] {
    OP_CLEAR_TRANSPARENT = 2'd0,
    OP_CLEAR_BLACK       = 2'd1,
    OP_BLEND             = 2'd2,
    OP_READ              = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 3'd0,
    CFG_HEIGHT   = 3'd1,
    CFG_X_OFFSET = 3'd2,
    CFG_Y_OFFSET = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  src_red;
    logic [7:0]  src_green;
    logic [7:0]  src_blue;
    logic [7:0]  src_alpha;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       out_of_range;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic calc_addr;
    logic fetch;
    logic mul;
    logic write;
    logic reply;
    logic clear_en;
    logic clear_zero;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_clear;
    logic is_read;
    logic in_canvas;
    logic clr_last;
  } dp_stat_t;

  // round(num / 255) for num up to 255 * 255; exact, ties cannot occur.
  function automatic logic [7:0] mix_round(input logic [16:0] num);
    logic [17:0] t;
    logic [17:0] s;
    t = 18'(num) + 18'd128;
    s = t + (t >> 8);
    return s[15:8];
  endfunction

endpackage

[rtl/lac_ctrl.sv]
// Sequencing state machine of the layer alpha compositor.
// Depends on lac_pkg for the command and status structs.
`timescale 1ns / 1ps

module lac_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  lac_pkg::dp_stat_t  stat_i,
  output lac_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    ST_INIT  = 7'b000_0001,
    ST_IDLE  = 7'b000_0010,
    ST_ADDR  = 7'b000_0100,
    ST_FETCH = 7'b000_1000,
    ST_MUL   = 7'b001_0000,
    ST_WRITE = 7'b010_0000,
    ST_CLEAR = 7'b100_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clear_en   = 1'b1;
        cmd_o.clear_zero = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd_o.calc_addr = 1'b1;
        state_d = stat_i.is_clear ? ST_CLEAR : ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        if (stat_i.is_read) begin
          state_d = ST_WRITE;
        end else if (stat_i.in_canvas) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_WRITE;
      end
      ST_WRITE: begin
        // a read finishes here with its reply, a blend with its store write
        cmd_o.reply = stat_i.is_read;
        cmd_o.write = !stat_i.is_read;
        state_d     = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not make the block busy");

  a_no_clear_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> (!cmd_o.clear_en && !cmd_o.write && !cmd_o.reply))
    else $error("store activity while idle");

  a_reply_not_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write |-> $past(cmd_o.mul))
    else $error("blend write without products");

endmodule

[rtl/lac_dp.sv]
// Datapath of the layer alpha compositor: config registers, canvas store,
// address check, blend arithmetic and result register. Depends on lac_pkg.
`timescale 1ns / 1ps

module lac_dp #(
  parameter int MAX_WIDTH  = lac_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lac_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lac_pkg::in_word_t              in_word_i,
  input  logic                           cfg_we_i,
  input  logic [lac_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  lac_pkg::dp_cmd_t               cmd_i,
  output lac_pkg::dp_stat_t              stat_o,
  output logic                           result_valid_o,
  output lac_pkg::out_word_t             result_o
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = 26;

  // Config registers
  logic [9:0]  width_q, height_q;
  logic [12:0] x_off_q, y_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 10'd512;
      height_q <= 10'd512;
      x_off_q  <= '0;
      y_off_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lac_pkg::CFG_WIDTH:    width_q  <= cfg_data_i[9:0];
        lac_pkg::CFG_HEIGHT:   height_q <= cfg_data_i[9:0];
        lac_pkg::CFG_X_OFFSET: x_off_q  <= cfg_data_i;
        lac_pkg::CFG_Y_OFFSET: y_off_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured word
  lac_pkg::in_word_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_word_i;
  end

  logic is_blend;
  assign is_blend = (item_q.opcode == lac_pkg::OP_BLEND);

  // Position check and store address
  logic signed [13:0] cx_s, cy_s;
  logic [12:0]        cx_u, cy_u;
  logic               inside_d, inside_q;
  logic [PROD_W-1:0]  addr_wide;
  logic [AW-1:0]      addr_d, addr_q;

  always_comb begin
    cx_s = signed'({2'b00, item_q.pixel_x});
    cy_s = signed'({2'b00, item_q.pixel_y});
    if (is_blend) begin
      cx_s = cx_s + signed'({x_off_q[12], x_off_q});
      cy_s = cy_s + signed'({y_off_q[12], y_off_q});
    end
    cx_u = cx_s[12:0];
    cy_u = cy_s[12:0];
    inside_d = !cx_s[13] && !cy_s[13]
            && (cx_u < {3'b000, width_q}) && (cx_u < 13'(MAX_WIDTH))
            && (cy_u < {3'b000, height_q}) && (cy_u < 13'(MAX_HEIGHT));
    addr_wide = PROD_W'(cy_u) * PROD_W'(MAX_WIDTH) + PROD_W'(cx_u);
    addr_d = inside_d ? addr_wide[AW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else if (cmd_i.calc_addr) begin
      inside_q <= inside_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_addr) addr_q <= addr_d;
  end

  // Clear pointer
  logic [AW-1:0] ptr_q;
  logic          clr_last;

  assign clr_last = (ptr_q == AW'(DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.clear_en) begin
      ptr_q <= clr_last ? '0 : ptr_q + 1'b1;
    end
  end

  // Canvas store, word layout {alpha, red, green, blue}
  logic [31:0] canvas_q [DEPTH];
  logic [31:0] rd_q;
  logic [31:0] fill_word, blend_word, wr_data;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) rd_q <= canvas_q[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) canvas_q[wr_addr] <= wr_data;
  end

  // Blend products, one lane per colour channel
  logic [7:0]  dst_ch [3];
  logic [7:0]  src_ch [3];
  logic [7:0]  inv_a;
  logic [15:0] p_src_q [3];
  logic [15:0] p_dst_q [3];
  logic [7:0]  mix [3];
  logic [8:0]  alpha_sum;
  logic [7:0]  alpha_new;

  assign dst_ch[0] = rd_q[23:16];
  assign dst_ch[1] = rd_q[15:8];
  assign dst_ch[2] = rd_q[7:0];
  assign src_ch[0] = item_q.src_red;
  assign src_ch[1] = item_q.src_green;
  assign src_ch[2] = item_q.src_blue;
  assign inv_a     = 8'd255 - item_q.src_alpha;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      for (int i = 0; i < 3; i++) begin
        p_src_q[i] <= 16'(src_ch[i]) * 16'(item_q.src_alpha);
        p_dst_q[i] <= 16'(dst_ch[i]) * 16'(inv_a);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mix[i] = lac_pkg::mix_round(17'(p_src_q[i]) + 17'(p_dst_q[i]));
    end
    alpha_sum = {1'b0, rd_q[31:24]} + {1'b0, item_q.src_alpha};
    alpha_new = alpha_sum[8] ? 8'hFF : alpha_sum[7:0];
  end

  assign blend_word = {alpha_new, mix[0], mix[1], mix[2]};
  assign fill_word  = (!cmd_i.clear_zero && item_q.opcode == lac_pkg::OP_CLEAR_BLACK)
                    ? lac_pkg::WORD_BLACK : lac_pkg::WORD_TRANSPARENT;
  assign wr_en   = cmd_i.clear_en || cmd_i.write;
  assign wr_addr = cmd_i.clear_en ? ptr_q : addr_q;
  assign wr_data = cmd_i.clear_en ? fill_word : blend_word;

  // Result register: one-cycle strobe
  logic                valid_q;
  lac_pkg::out_word_t  result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.reply;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.reply) begin
      if (inside_q) begin
        result_q.out_red      <= rd_q[23:16];
        result_q.out_green    <= rd_q[15:8];
        result_q.out_blue     <= rd_q[7:0];
        result_q.out_alpha    <= rd_q[31:24];
        result_q.out_of_range <= 1'b0;
      end else begin
        result_q.out_red      <= '0;
        result_q.out_green    <= '0;
        result_q.out_blue     <= '0;
        result_q.out_alpha    <= '0;
        result_q.out_of_range <= 1'b1;
      end
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  assign stat_o.is_clear  = (item_q.opcode == lac_pkg::OP_CLEAR_TRANSPARENT)
                         || (item_q.opcode == lac_pkg::OP_CLEAR_BLACK);
  assign stat_o.is_read   = (item_q.opcode == lac_pkg::OP_READ);
  assign stat_o.in_canvas = inside_q;
  assign stat_o.clr_last  = clr_last;

  a_write_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> inside_q)
    else $error("blend written for a position outside the canvas");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("result strobe held longer than one cycle");

  a_ptr_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.clear_en && clr_last) |=> (ptr_q == '0))
    else $error("clear pointer did not return to zero");

endmodule

[rtl/layer_alpha_compositor.sv]
// Top level of the layer alpha compositor: joins controller and datapath.
// Depends on lac_pkg, lac_ctrl and lac_dp.
`timescale 1ns / 1ps

// A read word passes ST_ADDR, ST_FETCH and ST_WRITE, where its result is registered.
// A word is taken only in idle, so one is in flight at a time. A blend inside
//   the canvas fetches, multiplies and writes back on the single store port.
// A blend outside ends after fetch. Clear walks the store one word a cycle.
// Reset: after rst_ni releases, busy stays high while the store is cleared
//   to transparent; config is taken always.
// Results are a one-cycle strobe; the receiver cannot stall.
module layer_alpha_compositor #(
  parameter int MAX_WIDTH  = lac_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lac_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command word in
  input  logic                           start,
  output logic                           busy,
  input  lac_pkg::in_word_t              in_word_i,
  // result word out
  output logic                           result_valid_o,
  output lac_pkg::out_word_t             result_o,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lac_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lac_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  lac_pkg::dp_cmd_t  cmd;
  lac_pkg::dp_stat_t stat;

  // Config registers accept a word every cycle.
  assign cfg_ready_o = 1'b1;

  lac_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  lac_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_word_i     (in_word_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

[test/tb_layer_alpha_compositor.sv]
// Self-checking testbench for layer_alpha_compositor: directed and random command words,
// checked against an in-bench model of the canvas store.
// Depends on lac_pkg and the layer_alpha_compositor RTL.
`timescale 1ns / 1ps

module tb_layer_alpha_compositor;
  import lac_pkg::*;

  localparam int CANVAS_COLS = MAX_WIDTH_DEF;
  localparam int CANVAS_ROWS = MAX_HEIGHT_DEF;
  // Longest in-flight work that leaves no result behind: a blend inside the canvas.
  localparam int SETTLE_CYCLES = 8;
  // Register index past the end of the register map; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd5;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_word_t              in_word_i = '0;
  logic                  result_valid_o;
  out_word_t             result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  layer_alpha_compositor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_word_i      (in_word_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Canvas model: written pixels live in a sparse map, everything else holds the
  // word of the last clear. A clear therefore costs nothing here.
  // ---------------------------------------------------------------------------
  logic [31:0] canvas_model [int unsigned];
  logic [31:0] canvas_fill = WORD_TRANSPARENT;

  // Mirror of the register file as the block should hold it.
  logic [9:0]  cfg_cols = 10'd512;
  logic [9:0]  cfg_rows = 10'd512;
  logic [12:0] cfg_xoff = '0;
  logic [12:0] cfg_yoff = '0;

  out_word_t pending_reads [$];
  int        fail_count = 0;

  function automatic logic [31:0] canvas_at(int unsigned addr);
    return canvas_model.exists(addr) ? canvas_model[addr] : canvas_fill;
  endfunction

  function automatic int cols_in_use();
    return (int'(cfg_cols) < CANVAS_COLS) ? int'(cfg_cols) : CANVAS_COLS;
  endfunction

  function automatic int rows_in_use();
    return (int'(cfg_rows) < CANVAS_ROWS) ? int'(cfg_rows) : CANVAS_ROWS;
  endfunction

  // round((s*a + d*(255-a)) / 255) in exact integers.
  function automatic logic [7:0] mix_chan(logic [7:0] s, logic [7:0] d, logic [7:0] a);
    int unsigned num;
    num = int'(s) * int'(a) + int'(d) * (255 - int'(a));
    return 8'((2 * num + 255) / 510);
  endfunction

  // Apply one accepted command word to the model; queue the result of a read.
  task automatic predict_word(in_word_t w);
    int          cx;
    int          cy;
    int unsigned addr;
    int unsigned sum_a;
    logic [31:0] d;
    out_word_t   r;
    case (w.opcode)
      OP_CLEAR_TRANSPARENT: begin
        canvas_model.delete();
        canvas_fill = WORD_TRANSPARENT;
      end
      OP_CLEAR_BLACK: begin
        canvas_model.delete();
        canvas_fill = WORD_BLACK;
      end
      OP_BLEND: begin
        cx = int'(w.pixel_x) + int'($signed(cfg_xoff));
        cy = int'(w.pixel_y) + int'($signed(cfg_yoff));
        // Drop pixels that land outside the canvas in use.
        if (cx >= 0 && cy >= 0 && cx < cols_in_use() && cy < rows_in_use()) begin
          addr = int'(cy) * CANVAS_COLS + int'(cx);
          d = canvas_at(addr);
          sum_a = int'(d[31:24]) + int'(w.src_alpha);
          if (sum_a > 255) sum_a = 255;
          canvas_model[addr] = {8'(sum_a),
                                mix_chan(w.src_red,   d[23:16], w.src_alpha),
                                mix_chan(w.src_green, d[15:8],  w.src_alpha),
                                mix_chan(w.src_blue,  d[7:0],   w.src_alpha)};
        end
      end
      default: begin
        r = '0;
        if (int'(w.pixel_x) >= cols_in_use() || int'(w.pixel_y) >= rows_in_use()) begin
          r.out_of_range = 1'b1;
        end else begin
          d = canvas_at(int'(w.pixel_y) * CANVAS_COLS + int'(w.pixel_x));
          r.out_red   = d[23:16];
          r.out_green = d[15:8];
          r.out_blue  = d[7:0];
          r.out_alpha = d[31:24];
        end
        pending_reads = {pending_reads, r};
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobed result word must match the oldest pending read.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  out_word_t read_want;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_reads.size() == 0) begin
        $error("result word with no read pending");
        fail_count++;
      end else begin
        read_want = pending_reads.pop_front();
        check_field("out_red",      read_want.out_red,      result_o.out_red);
        check_field("out_green",    read_want.out_green,    result_o.out_green);
        check_field("out_blue",     read_want.out_blue,     result_o.out_blue);
        check_field("out_alpha",    read_want.out_alpha,    result_o.out_alpha);
        check_field("out_of_range", read_want.out_of_range, result_o.out_of_range);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered and left right after a rising edge.
  // ---------------------------------------------------------------------------
  function automatic in_word_t mk_word(opcode_e op, int x, int y, logic [7:0] r,
                                       logic [7:0] g, logic [7:0] b, logic [7:0] a);
    in_word_t w;
    w.opcode    = op;
    w.pixel_x   = 12'(x);
    w.pixel_y   = 12'(y);
    w.src_red   = r;
    w.src_green = g;
    w.src_blue  = b;
    w.src_alpha = a;
    return w;
  endfunction

  // Send one command word after a random gap; hold start high through a zero
  // gap so back-to-back words stream without a bubble.
  task automatic issue_word(in_word_t w);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (busy);
    predict_word(w);
  endtask

  // Drop start, wait for every read result and for the block to go idle, then
  // give an in-flight blend time to write back.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_reads.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; leave valid high unless this is the last write of a burst.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data,
                           bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WIDTH:    cfg_cols = data[9:0];
      CFG_HEIGHT:   cfg_rows = data[9:0];
      CFG_X_OFFSET: cfg_xoff = data;
      CFG_Y_OFFSET: cfg_yoff = data;
      default: ;
    endcase
  endtask

  // Program all four registers; size registers carry junk above their 10 bits.
  task automatic apply_setup(int cols, int rows, int xoff, int yoff);
    settle();
    write_reg(CFG_WIDTH,    {3'($urandom), 10'(cols)}, 1'b0);
    write_reg(CFG_HEIGHT,   {3'($urandom), 10'(rows)}, 1'b0);
    write_reg(CFG_X_OFFSET, 13'(xoff), 1'b0);
    write_reg(CFG_Y_OFFSET, 13'(yoff), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Store comes out of reset transparent; reads past the edge flag out of range.
  task automatic test_reset_state();
    issue_word(mk_word(OP_READ, 0, 0, 8'hAA, 8'h55, 8'hFF, 8'h00));
    issue_word(mk_word(OP_READ, CANVAS_COLS - 1, CANVAS_ROWS - 1, 0, 0, 0, 0));
    issue_word(mk_word(OP_READ, CANVAS_COLS, 0, 0, 0, 0, 0));
    issue_word(mk_word(OP_READ, 0, 4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // Opaque, half, and zero alpha over the same pixel; alpha saturation; far corner.
  task automatic test_blend_math();
    issue_word(mk_word(OP_BLEND, 0, 0, 8'hFF, 8'h00, 8'h80, 8'hFF));
    issue_word(mk_word(OP_READ,  0, 0, 0, 0, 0, 0));
    issue_word(mk_word(OP_BLEND, 0, 0, 8'h00, 8'hFF, 8'h07, 8'h80));
    issue_word(mk_word(OP_READ,  0, 0, 0, 0, 0, 0));
    issue_word(mk_word(OP_BLEND, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    issue_word(mk_word(OP_READ,  0, 0, 0, 0, 0, 0));
    issue_word(mk_word(OP_BLEND, CANVAS_COLS - 1, CANVAS_ROWS - 1, 8'hFF, 8'hFF, 8'hFF,
                       8'hFF));
    issue_word(mk_word(OP_READ,  CANVAS_COLS - 1, CANVAS_ROWS - 1, 0, 0, 0, 0));
  endtask

  // Extreme offsets: land a pixel from the far corner of layer space, drop ones
  // that fall off the left edge or past the right edge.
  task automatic test_layer_offsets();
    apply_setup(512, 512, -4000, -4000);
    issue_word(mk_word(OP_BLEND, 4000, 4001, 8'h12, 8'h34, 8'h56, 8'hC0));
    issue_word(mk_word(OP_READ,  0, 1, 0, 0, 0, 0));
    issue_word(mk_word(OP_BLEND, 3999, 4000, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    apply_setup(512, 512, 4095, -4096);
    issue_word(mk_word(OP_BLEND, 0, 4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    issue_word(mk_word(OP_READ,  0, 0, 0, 0, 0, 0));
  endtask

  // Zero width leaves nothing inside; oversized width clamps to the store.
  task automatic test_canvas_size();
    apply_setup(0, 512, 0, 0);
    issue_word(mk_word(OP_READ,  0, 0, 0, 0, 0, 0));
    issue_word(mk_word(OP_BLEND, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    apply_setup(1023, 1, 0, 0);
    issue_word(mk_word(OP_BLEND, CANVAS_COLS - 1, 0, 8'h80, 8'h40, 8'h20, 8'h60));
    issue_word(mk_word(OP_READ,  CANVAS_COLS - 1, 0, 0, 0, 0, 0));
    issue_word(mk_word(OP_READ,  0, 1, 0, 0, 0, 0));
  endtask

  // A write past the register map must not disturb the canvas size.
  task automatic test_unused_register();
    settle();
    write_reg(CFG_IDX_UNUSED, '0, 1'b1);
    issue_word(mk_word(OP_READ, 3, 0, 0, 0, 0, 0));
  endtask

  // Both clears walk the full store; blend on black, then wipe to transparent.
  task automatic test_clears();
    apply_setup(512, 512, 0, 0);
    issue_word(mk_word(OP_CLEAR_BLACK, 0, 0, 0, 0, 0, 0));
    issue_word(mk_word(OP_READ,  5, 5, 0, 0, 0, 0));
    issue_word(mk_word(OP_BLEND, 5, 5, 8'hC8, 8'h64, 8'h32, 8'h64));
    issue_word(mk_word(OP_READ,  5, 5, 0, 0, 0, 0));
    issue_word(mk_word(OP_CLEAR_TRANSPARENT, 0, 0, 0, 0, 0, 0));
    issue_word(mk_word(OP_READ,  5, 5, 0, 0, 0, 0));
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------

  // Pick a canvas coordinate: mostly a small corner window so blends and reads
  // hit the same pixels, sometimes the far edge, sometimes just off the canvas.
  function automatic int aim_coord(int extent);
    int pick;
    int lim;
    pick = $urandom_range(0, 9);
    lim  = (extent < 10) ? extent : 10;
    if (extent == 0) return int'($urandom_range(0, 2)) - 1;
    if (pick < 7) return int'($urandom_range(0, lim - 1));
    if (pick < 9) return extent - 2 + int'($urandom_range(0, 2));
    return -1;
  endfunction

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_traffic(int count);
    in_word_t w;
    int       cx;
    int       cy;
    for (int i = 0; i < count; i++) begin
      w.opcode    = ($urandom_range(0, 99) < 55) ? OP_BLEND : OP_READ;
      w.src_red   = 8'($urandom);
      w.src_green = 8'($urandom);
      w.src_blue  = 8'($urandom);
      w.src_alpha = pick_alpha();
      if ($urandom_range(0, 99) < 15) begin
        // Noise: anywhere in the 12-bit coordinate space.
        w.pixel_x = 12'($urandom);
        w.pixel_y = 12'($urandom);
      end else begin
        cx = aim_coord(cols_in_use());
        cy = aim_coord(rows_in_use());
        if (w.opcode == OP_BLEND) begin
          // Undo the layer offset so the pixel lands where aimed.
          cx = cx - int'($signed(cfg_xoff));
          cy = cy - int'($signed(cfg_yoff));
        end
        w.pixel_x = 12'(cx);
        w.pixel_y = 12'(cy);
      end
      issue_word(w);
      // Now and then hold off until every read has come back.
      if ($urandom_range(0, 59) == 0) settle();
    end
  endtask

  task automatic test_random_traffic();
    apply_setup(512, 512, 0, 0);
    run_traffic(150);
    apply_setup($urandom_range(1, 16), $urandom_range(1, 16),
                int'($urandom_range(0, 12)) - 6, int'($urandom_range(0, 12)) - 6);
    run_traffic(150);
    apply_setup(1023, 3, -300, 2);
    run_traffic(150);
    apply_setup(1, 1, -4095, -4095);
    run_traffic(150);
    settle();
    write_reg(CFG_WIDTH,    13'($urandom), 1'b0);
    write_reg(CFG_HEIGHT,   13'($urandom), 1'b0);
    write_reg(CFG_X_OFFSET, 13'($urandom), 1'b0);
    write_reg(CFG_Y_OFFSET, 13'($urandom), 1'b1);
    run_traffic(150);
    apply_setup($urandom_range(1, 16), $urandom_range(1, 16),
                -int'($urandom_range(1, 40)), -int'($urandom_range(1, 40)));
    run_traffic(150);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_blend_math();
    test_layer_offsets();
    test_canvas_size();
    test_unused_register();
    test_clears();
    test_random_traffic();

    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: the time limit leaves room for the reset clear plus two full clears.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
